/* sv/srtf_pkg.sv */
// srtf_pkg: shared types and constants of the srtf process scheduler
// used by srtf_cell, srtf_scan and srtf_process_scheduler_core; no dependencies
package srtf_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned TimeW = 21;
  localparam logic [TimeW-1:0] TIME_MAX = 21'h1F_FFFF;

  // input operation codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // one process slot
  typedef struct packed {
    logic [IdW-1:0] id;
    logic [IdW-1:0] arr;
    logic [IdW-1:0] rem;
  } slot_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } state_t;

  // control from sequencer to the cell row and scanner
  typedef struct packed {
    logic shift;
    logic clr;
    logic upd;
  } ctrl_t;

endpackage

/* sv/srtf_cell.sv */
// srtf_cell: one process slot of the rotating slot ring
// depends on srtf_pkg for slot_t
module srtf_cell (
  input  logic           clk,
  input  logic           shift,
  input  logic           load,
  input  logic           dec,
  input  srtf_pkg::slot_t load_slot,
  input  srtf_pkg::slot_t nbr,
  output srtf_pkg::slot_t slot
);
  import srtf_pkg::*;

  // load, run one unit, or take the neighbor's slot
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= load_slot;
    end else if (dec) begin
      slot.rem <= slot.rem - IdW'(1);
    end else if (shift) begin
      slot <= nbr;
    end
  end

endmodule

/* sv/srtf_scan.sv */
// srtf_scan: running minimum of remaining time over the ring head
// depends on srtf_pkg for slot_t and widths
module srtf_scan #(
  parameter int unsigned IDX_W = 4
) (
  input  logic                      clk,
  input  logic                      clr,
  input  logic                      step,
  input  logic                      in_range,
  input  logic [IDX_W-1:0]          idx,
  input  srtf_pkg::slot_t           head,
  input  logic [srtf_pkg::TimeW-1:0] now,
  output logic                      found,
  output logic [IDX_W-1:0]          best_idx,
  output logic [srtf_pkg::IdW-1:0]  best_rem,
  output logic [srtf_pkg::IdW-1:0]  best_id,
  output logic                      other_nz
);
  import srtf_pkg::*;

  logic live;
  logic elig;
  logic take;

  // slot has work left, has arrived, and beats the current best
  always_comb begin
    live = in_range && (head.rem != '0);
    elig = live && ({{(TimeW-IdW){1'b0}}, head.arr} <= now);
    take = elig && (!found || (head.rem < best_rem));
  end

  // best so far, plus whether any other slot still has work
  always_ff @(posedge clk) begin
    if (clr) begin
      found    <= 1'b0;
      other_nz <= 1'b0;
    end else if (step) begin
      if (take) begin
        found    <= 1'b1;
        best_idx <= idx;
        best_rem <= head.rem;
        best_id  <= head.id;
        if (found) begin
          other_nz <= 1'b1;
        end
      end else if (live) begin
        other_nz <= 1'b1;
      end
    end
  end

endmodule

/* sv/srtf_process_scheduler_core.sv */
// srtf_process_scheduler_core: preemptive shortest-remaining-time-first scheduler
// depends on srtf_pkg, srtf_cell and srtf_scan
//
// Input channel (in_valid/in_stall): func selects load or tick. A load stores
// proc_id, arrive_at and burst_len in the next free slot; loads into a full
// table are dropped. A load gives no result.
// A tick rotates the ring of MAX_PROCS slot cells once around, one slot per
// cycle past the scanner at the head, which keeps the least remaining time
// among arrived slots (ties to the lowest slot). An update step then runs the
// pick for one unit and fills the output register.
// Output channel (out_valid/out_stall): one result per tick. The output
// register holds while out_stall is high; loads are still taken then, and a
// finished tick waits in its update step until the register frees up.
// Reset (rst, synchronous) empties the table, zeroes the time and forgets the
// last run process; slot contents are not cleared.
module srtf_process_scheduler_core #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      func,
  input  logic [srtf_pkg::IdW-1:0]  proc_id,
  input  logic [srtf_pkg::IdW-1:0]  arrive_at,
  input  logic [srtf_pkg::IdW-1:0]  burst_len,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [srtf_pkg::IdW-1:0]  run_id,
  output logic                      idle,
  output logic                      new_in_order,
  output logic                      finished,
  output logic                      all_done,
  output logic [srtf_pkg::TimeW-1:0] tick_time
);
  import srtf_pkg::*;

  localparam int unsigned IW = $clog2(MAX_PROCS);
  localparam int unsigned UW = $clog2(MAX_PROCS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);
  localparam logic [UW-1:0] FULL = UW'(MAX_PROCS);

  state_t          state, state_next;
  ctrl_t           ctrl;
  logic            in_xfer;
  logic            out_xfer;
  logic [IW-1:0]   scan_idx;
  logic [UW-1:0]   used;
  logic [TimeW-1:0] now_time;
  logic [IdW-1:0]  last_run;
  logic            have_last;
  slot_t           load_slot;
  slot_t           cells [MAX_PROCS];

  logic            found;
  logic [IW-1:0]   best_idx;
  logic [IdW-1:0]  best_rem;
  logic [IdW-1:0]  best_id;
  logic            other_nz;
  logic            last_unit;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign load_slot = '{id: proc_id, arr: arrive_at, rem: burst_len};
  assign last_unit = (best_rem == IdW'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && (func == FUNC_TICK)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx == LAST_IDX) state_next = ST_UPD;
      end
      ST_UPD: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = (state != ST_IDLE);
    ctrl.shift = (state == ST_SCAN);
    ctrl.clr   = (state == ST_IDLE) && in_valid && (func == FUNC_TICK);
    ctrl.upd   = (state == ST_UPD) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan position, zero at home
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (ctrl.shift) begin
      scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + IW'(1);
    end
  end

  // table fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (in_xfer && (func == FUNC_LOAD) && (used != FULL)) begin
      used <= used + UW'(1);
    end
  end

  // ring of slot cells, rotating toward cell 0
  for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
    srtf_cell u_cell (
      .clk       (clk),
      .shift     (ctrl.shift),
      .load      (in_xfer && (func == FUNC_LOAD) && (used == UW'(k))),
      .dec       (ctrl.upd && found && (best_idx == IW'(k))),
      .load_slot (load_slot),
      .nbr       (cells[(k + 1) % MAX_PROCS]),
      .slot      (cells[k])
    );
  end

  // minimum search at the ring head
  srtf_scan #(.IDX_W(IW)) u_scan (
    .clk      (clk),
    .clr      (ctrl.clr),
    .step     (ctrl.shift),
    .in_range ({{(UW-IW){1'b0}}, scan_idx} < used),
    .idx      (scan_idx),
    .head     (cells[0]),
    .now      (now_time),
    .found    (found),
    .best_idx (best_idx),
    .best_rem (best_rem),
    .best_id  (best_id),
    .other_nz (other_nz)
  );

  // time, run order history and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      now_time  <= '0;
      last_run  <= '0;
      have_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.upd) begin
        out_valid <= 1'b1;
        if (now_time != TIME_MAX) now_time <= now_time + TimeW'(1);
        if (found) begin
          last_run  <= best_id;
          have_last <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      run_id       <= found ? best_id : '0;
      idle         <= !found;
      new_in_order <= found && (!have_last || (last_run != best_id));
      finished     <= found && last_unit;
      all_done     <= !other_nz && (!found || last_unit);
      tick_time    <= now_time;
    end
  end

  // checks
  a_used_max: assert property (@(posedge clk) disable iff (rst) used <= FULL)
    else $error("slot count beyond table size");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> (run_id == '0) && !finished && !new_in_order)
    else $error("idle result carries a process");

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (scan_idx == LAST_IDX) |=> (state == ST_UPD) && (scan_idx == '0))
    else $error("ring did not return home after one rotation");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> !idle)
    else $error("finished flag on idle tick");

endmodule
